### hw/rtl/avmpq_pkg.sv
// Shared types, constants and ordering helpers for the magnitude-ordered priority queue.
package avmpq_pkg;

  // Width of one stored value and default number of cells
  localparam int unsigned DataW        = 32;
  localparam int unsigned DefaultDepth = 64;
  // Ordering key: magnitude with one tie-break bit below it
  localparam int unsigned KeyW         = DataW + 1;

  typedef logic signed [DataW-1:0] data_t;
  typedef logic [KeyW-1:0]         key_t;

  // Operation broadcast to every cell in a cycle
  typedef struct packed {
    logic  ins;   // insert new_val at its sorted position
    logic  pop;   // shift everything one cell toward the head
    data_t new_val;
  } cell_ctl_t;

  // Magnitude in the upper bits; on equal magnitude the negative value ranks first.
  // The most negative pattern gets magnitude 2^31, which still fits unsigned.
  function automatic key_t order_key(input data_t v);
    logic [DataW-1:0] mag;
    begin
      mag = v[DataW-1] ? (~v + 1'b1) : v;
      return {mag, ~v[DataW-1]};
    end
  endfunction

endpackage

### hw/rtl/avmpq_cell.sv
// One cell of the sorted shift array: holds an entry and moves it toward its neighbors.
module avmpq_cell (
  input  logic                  clk,
  input  avmpq_pkg::cell_ctl_t  ctl,
  input  logic                  vacant,      // no entry stored here
  input  logic                  left_goes,   // new value belongs at or before the left cell
  input  avmpq_pkg::data_t      left_val,
  input  avmpq_pkg::data_t      right_val,
  output logic                  goes_here,   // new value ranks before this cell's entry
  output avmpq_pkg::data_t      val_r
);
  import avmpq_pkg::*;

  data_t val_nxt;

  // New value ranks before this entry; an empty cell always accepts
  assign goes_here = vacant || (order_key(ctl.new_val) < order_key(val_r));

  // Pop shifts toward the head; insert shifts toward the tail from the insert point
  always_comb begin
    val_nxt = val_r;
    if (ctl.pop) begin
      val_nxt = right_val;
    end else if (ctl.ins) begin
      if (left_goes) begin
        val_nxt = left_val;
      end else if (goes_here) begin
        val_nxt = ctl.new_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

### hw/rtl/abs_value_min_priority_queue_core.sv
// Top level of the magnitude-ordered priority queue built as a systolic sorted shift array.
//
//   channel  direction  signals                                   beat
//   in       input      in_valid, in_ready, in_value              one insert or removal
//   out      output     out_valid, out_ready, out_popped_value,   one removed entry
//                       out_overflow_seen
//
// All cells compare each accepted beat's broadcast value in parallel and shift
// by one position at the same edge, so one beat per cycle while in_ready is high.
// A removal's result appears in the output register the cycle after acceptance.
// in_ready drops only while a result waits in the output register and out_ready is low.
// Reset clears the fill count, the overflow flag and the output valid; cell contents
// are not cleared, as cells at or beyond the fill count are never read.
module abs_value_min_priority_queue_core #(
  parameter int unsigned DEPTH = avmpq_pkg::DefaultDepth
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  avmpq_pkg::data_t        in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output avmpq_pkg::data_t        out_popped_value,
  output logic                    out_overflow_seen
);
  import avmpq_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0] occ_r, occ_nxt;
  logic            ovf_r, ovf_nxt;
  logic            out_valid_r, out_valid_nxt;
  data_t           out_val_r, out_val_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            accept;
  logic            is_pop;
  logic            full;
  logic            empty;
  cell_ctl_t       ctl;

  data_t           cell_val [DEPTH];
  logic            cell_goes[DEPTH];
  logic            cell_vac [DEPTH];

  // Handshake and operation decode
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_pop   = (in_value == '0);
  assign full     = (occ_r == CntW'(DEPTH));
  assign empty    = (occ_r == '0);

  assign ctl.ins     = accept && !is_pop && !full;
  assign ctl.pop     = accept && is_pop && !empty;
  assign ctl.new_val = in_value;

  // Row of cells, head at index 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    assign cell_vac[g] = (occ_r <= CntW'(g));

    avmpq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .vacant    (cell_vac[g]),
      .left_goes ((g == 0) ? 1'b0 : cell_goes[(g == 0) ? 0 : g - 1]),
      .left_val  ((g == 0) ? data_t'(0) : cell_val[(g == 0) ? 0 : g - 1]),
      .right_val ((g == DEPTH - 1) ? data_t'(0) : cell_val[(g == DEPTH - 1) ? g : g + 1]),
      .goes_here (cell_goes[g]),
      .val_r     (cell_val[g])
    );
  end

  // Fill count, sticky overflow and output register
  always_comb begin
    occ_nxt       = occ_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_ovf_nxt   = out_ovf_r;
    if (ctl.ins) begin
      occ_nxt = occ_r + 1'b1;
    end
    if (accept && !is_pop && full) begin
      ovf_nxt = 1'b1;
    end
    if (ctl.pop) begin
      occ_nxt = occ_r - 1'b1;
    end
    if (accept && is_pop) begin
      out_valid_nxt = 1'b1;
      out_val_nxt   = empty ? data_t'(0) : cell_val[0];
      out_ovf_nxt   = ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r       <= occ_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_popped_value  = out_val_r;
  assign out_overflow_seen = out_ovf_r;

`ifndef SYNTHESIS
  // Fill count never passes the number of cells
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CntW'(DEPTH))
    else $error("fill count beyond depth");

  // Insert into a full array is dropped and raises the sticky flag
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !is_pop && full) |=> (ovf_r && occ_r == CntW'(DEPTH)))
    else $error("full insert not dropped");

  // Removal from an empty array returns zero on the next cycle
  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_pop && empty) |=> (out_valid && out_popped_value == '0))
    else $error("empty removal did not return zero");

  // Every accepted removal shows a result with the current overflow flag
  a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_pop) |=> (out_valid && out_overflow_seen == $past(ovf_r)))
    else $error("removal result missing");
`endif

endmodule

### dv/avmpq_checker.sv
// Channel monitor for the priority queue: predicts every removal and compares it.
module avmpq_checker #(
  parameter int unsigned DEPTH = avmpq_pkg::DefaultDepth
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_ready,
  input  avmpq_pkg::data_t in_value,
  input  logic             out_valid,
  input  logic             out_ready,
  input  avmpq_pkg::data_t out_popped_value,
  input  logic             out_overflow_seen,
  output int               fail_count,
  output int               pending,
  output int               checked,
  output logic             ovf_model
);
  timeunit 1ns;
  timeprecision 1ps;
  import avmpq_pkg::*;

  // One predicted removal beat
  typedef struct packed {
    data_t value;
    logic  ovf;
  } removal_t;

  data_t    sorted_store[$];   // model of the cells, head first
  removal_t removals_due[$];   // removals accepted, result not yet seen
  logic     ovf_flag;
  int       mismatches;
  int       results_seen;

  // Smaller magnitude leaves first; equal magnitude: the negative one first
  function automatic bit leaves_first(data_t a, data_t b);
    logic [DataW-1:0] mag_a;
    logic [DataW-1:0] mag_b;
    mag_a = a[DataW-1] ? (32'd0 - a) : a;
    mag_b = b[DataW-1] ? (32'd0 - b) : b;
    if (mag_a != mag_b) return mag_a < mag_b;
    return a < b;
  endfunction

  // Update the model for one accepted input beat
  task automatic apply_beat(data_t v);
    removal_t r;
    int       pos;
    if (v != 0) begin
      if (sorted_store.size() >= DEPTH) begin
        ovf_flag = 1'b1;
      end else begin
        pos = 0;
        while (pos < sorted_store.size() && !leaves_first(v, sorted_store[pos])) pos++;
        sorted_store.insert(pos, v);
      end
    end else begin
      if (sorted_store.size() == 0) begin
        r.value = '0;
      end else begin
        r.value = sorted_store.pop_front();
      end
      r.ovf = ovf_flag;
      removals_due.insert(removals_due.size(), r);
    end
  endtask

  // Compare one output beat against the oldest prediction
  task automatic check_beat(data_t got_v, logic got_o);
    removal_t want;
    results_seen++;
    if (removals_due.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected result beat, expected none, got value %0d overflow %0b",
               $time, got_v, got_o);
    end else begin
      want = removals_due.pop_front();
      if (got_v !== want.value) begin
        mismatches++;
        $display("%0t: popped_value expected %0d, got %0d", $time, want.value, got_v);
      end
      if (got_o !== want.ovf) begin
        mismatches++;
        $display("%0t: overflow_seen expected %0b, got %0b", $time, want.ovf, got_o);
      end
    end
  endtask

  // Result first: a removal accepted this edge cannot show up before the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      sorted_store.delete();
      removals_due.delete();
      ovf_flag     = 1'b0;
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (out_valid && out_ready) check_beat(out_popped_value, out_overflow_seen);
      if (in_valid && in_ready) apply_beat(in_value);
    end
    fail_count <= mismatches;
    pending    <= removals_due.size();
    checked    <= results_seen;
    ovf_model  <= ovf_flag;
  end

endmodule

### dv/abs_value_min_priority_queue_core_tb.sv
// Top of the priority queue testbench: clock, reset, stimulus, receiver and verdict.
module abs_value_min_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import avmpq_pkg::*;

  localparam int unsigned QDepth      = DefaultDepth;
  localparam int          RandomBeats = 1250;
  localparam int          HoldCycles  = 300;
  localparam int          CycleLimit  = 400000;

  // Zero on the input asks for a removal
  localparam data_t PopReq     = '0;
  localparam data_t MaxPos     = 32'sh7FFFFFFF;
  localparam data_t MaxNeg     = -32'sh7FFFFFFF;
  localparam data_t MinPattern = data_t'(32'h80000000);

  // Empty removal, ties at equal magnitude, extremes, drain down to empty again
  localparam data_t Directed[21] = '{
    PopReq, 5, -5, 5, -5, PopReq, PopReq, PopReq, PopReq, PopReq,
    MaxPos, MaxNeg, MinPattern, 1, -1,
    PopReq, PopReq, PopReq, PopReq, PopReq, PopReq
  };

  logic  clk = 1'b0;
  logic  rst_n;
  logic  in_valid;
  logic  in_ready;
  data_t in_value;
  logic  out_valid;
  logic  out_ready;
  data_t out_popped_value;
  logic  out_overflow_seen;

  int    fail_count;
  int    pending;
  int    checked;
  logic  ovf_model;

  int    accepted_beats;
  int    holds_done;
  int    fills_done;
  int    cycles;
  bit    sender_steady;

  always #5 clk = ~clk;

  abs_value_min_priority_queue_core #(
    .DEPTH(QDepth)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_overflow_seen(out_overflow_seen)
  );

  avmpq_checker #(
    .DEPTH(QDepth)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_overflow_seen(out_overflow_seen),
    .fail_count       (fail_count),
    .pending          (pending),
    .checked          (checked),
    .ovf_model        (ovf_model)
  );

  // Idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Nonzero insert value: small values for ties, full-width values, extremes
  function automatic data_t insert_value();
    int    r;
    data_t v;
    r = $urandom_range(99);
    if (r < 35) begin
      v = $urandom_range(1, 8);
    end else if (r < 50) begin
      v = $urandom_range(1, 1000);
    end else if (r < 92) begin
      v = $urandom();
    end else begin
      case ($urandom_range(4))
        0:       v = MaxPos;
        1:       v = MaxNeg;
        2:       v = MinPattern;
        3:       v = 1;
        default: v = -1;
      endcase
    end
    if (r < 50 && $urandom_range(1) == 1) v = -v;
    if (v == 0) v = 1;
    return v;
  endfunction

  // Offer one input beat and hold it until accepted
  task automatic send_beat(data_t v);
    int gap;
    gap = sender_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    accepted_beats++;
  endtask

  // Run budget
  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Receiver: random ready, plus two long hold-offs so the input stalls
  initial begin
    int stretch;
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (holds_done < 2 && accepted_beats >= (holds_done == 0 ? 300 : 1100)) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        holds_done++;
      end
      out_ready <= 1'b1;
      stretch = ($urandom_range(3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (stretch) @(posedge clk);
      gap = idle_len();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int sent_rand;
    int seg_len;
    int pop_pct;
    int n;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_value <= '0;
    accepted_beats = 0;
    holds_done     = 0;
    fills_done     = 0;
    sender_steady  = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (Directed[i]) send_beat(Directed[i]);

    sent_rand = 0;
    while (sent_rand < RandomBeats) begin
      sender_steady = ($urandom_range(3) == 0);
      if ((fills_done == 0 && sent_rand > 700) ||
          (sent_rand > 500 && $urandom_range(3) == 0)) begin
        // fill past capacity, then drain with a few removals on the empty store
        n = QDepth + $urandom_range(1, 16);
        repeat (n) send_beat(insert_value());
        seg_len = n + $urandom_range(1, 4);
        repeat (seg_len) send_beat(PopReq);
        sent_rand += n + seg_len;
        fills_done++;
      end else begin
        // mixed inserts and removals at a random removal rate
        seg_len = $urandom_range(20, 120);
        case ($urandom_range(2))
          0:       pop_pct = 25;
          1:       pop_pct = 45;
          default: pop_pct = 65;
        endcase
        repeat (seg_len) begin
          if ($urandom_range(99) < pop_pct) send_beat(PopReq);
          else send_beat(insert_value());
        end
        sent_rand += seg_len;
      end
    end
    in_valid <= 1'b0;

    // wait for the last removals to come out, then a short drain
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);

    $display("run: %0d input beats, %0d removals checked, %0d fills past capacity",
             accepted_beats, checked, fills_done);
    $display("run: %0d long receiver hold-offs, overflow flag reached %0b",
             holds_done, ovf_model);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/avmpq_pkg.sv
hw/rtl/avmpq_cell.sv
hw/rtl/abs_value_min_priority_queue_core.sv
dv/avmpq_checker.sv
dv/abs_value_min_priority_queue_core_tb.sv
